@@ design/bem_pkg.sv @@
// ----------------------------------------------------------------------------
// bem_pkg: shared types and constants for the station address / name table
// Request and result payloads, slot layout, status and mode codes, FSM states.
// ----------------------------------------------------------------------------
package bem_pkg;

  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 6;
  localparam int WORD_W     = 64;
  localparam int NAME_BYTES = 32;
  localparam int NAME_W     = NAME_BYTES * 8;

  localparam logic MODE_UPSERT = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_REVEALED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_WRITE,
    S_DONE
  } bem_state_t;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] station_address;
    logic [LEN_W-1:0]  name_length;
    logic [WORD_W-1:0] name_word0;
    logic [WORD_W-1:0] name_word1;
    logic [WORD_W-1:0] name_word2;
    logic [WORD_W-1:0] name_word3;
  } bem_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  found_length;
    logic [WORD_W-1:0] found_word0;
    logic [WORD_W-1:0] found_word1;
    logic [WORD_W-1:0] found_word2;
    logic [WORD_W-1:0] found_word3;
  } bem_rsp_t;

  // One slot of the name store: trimmed length and name, byte 0 in low bits.
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [NAME_W-1:0] name;
  } bem_slot_t;

  // Top level to sequencer.
  typedef struct packed {
    logic              start;
    logic              mode;
    logic              len_ok;
    logic              len_nz;
    logic              out_free;
    logic [ADDR_W-1:0] key;
  } bem_ctrl_in_t;

  // Sequencer to top level.
  typedef struct packed {
    logic       idle;
    logic       done;
    logic       hit;
    logic [1:0] status;
    logic       ram_rd;
    logic       ram_wr;
  } bem_ctrl_out_t;

endpackage

@@ design/bssid_essid_map_upsert.sv @@
// ----------------------------------------------------------------------------
// bssid_essid_map_upsert: station address to network name table
// Upsert with reveal of an empty name, and lookup, over TABLE_ENTRIES slots.
// ----------------------------------------------------------------------------
// The address scan passes every slot, one per cycle, through a single compare
//   unit; a new request is held off until the sequencer is back in idle.
// A request can be accepted while the previous result still waits on out_stall.
// Reset: synchronous, active low; clears all slot valid bits, FSM and handshake.
module bssid_essid_map_upsert import bem_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bem_req_t in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bem_rsp_t out_data
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  bem_req_t      req_r;
  bem_rsp_t      out_data_r;
  logic          out_valid_r;
  bem_ctrl_in_t  ctl_in;
  bem_ctrl_out_t ctl_out;
  logic [IW-1:0] ram_idx;
  bem_slot_t     wr_slot;
  bem_slot_t     rd_slot;
  logic          accept;

  // Hold off new requests until the sequencer is back in idle.
  assign in_stall  = !ctl_out.idle;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Capture the request; it stays put for the whole scan and update.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
  end

  assign ctl_in.start    = accept;
  assign ctl_in.mode     = req_r.mode;
  assign ctl_in.len_ok   = (req_r.name_length <= LEN_W'(NAME_BYTES));
  assign ctl_in.len_nz   = (req_r.name_length != '0);
  assign ctl_in.out_free = !out_valid_r || !out_stall;
  assign ctl_in.key      = req_r.station_address;

  // Trim the incoming name at its first zero byte before it is stored.
  bem_name_trim u_trim (
    .name_in  ({req_r.name_word3, req_r.name_word2, req_r.name_word1, req_r.name_word0}),
    .len_in   (req_r.name_length),
    .len_out  (wr_slot.len),
    .name_out (wr_slot.name)
  );

  bem_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .IW            (IW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_in     (ctl_in),
    .stored_len (rd_slot.len),
    .ctl_out    (ctl_out),
    .ram_idx    (ram_idx)
  );

  // Slot name store: read and written at the matched slot, else at the free slot.
  bem_name_ram #(
    .DEPTH (TABLE_ENTRIES),
    .IW    (IW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (ctl_out.ram_rd),
    .wr_en   (ctl_out.ram_wr),
    .idx     (ram_idx),
    .wr_slot (wr_slot),
    .rd_slot (rd_slot)
  );

  // Output register: load on finish, drop once the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl_out.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_out.done) begin
      out_data_r.status <= ctl_out.status;
      // Stored names are already zero past their length, so pass them as is.
      if ((req_r.mode == MODE_LOOKUP) && ctl_out.hit) begin
        out_data_r.found_length <= rd_slot.len;
        out_data_r.found_word0  <= rd_slot.name[0*WORD_W +: WORD_W];
        out_data_r.found_word1  <= rd_slot.name[1*WORD_W +: WORD_W];
        out_data_r.found_word2  <= rd_slot.name[2*WORD_W +: WORD_W];
        out_data_r.found_word3  <= rd_slot.name[3*WORD_W +: WORD_W];
      end else begin
        out_data_r.found_length <= '0;
        out_data_r.found_word0  <= '0;
        out_data_r.found_word1  <= '0;
        out_data_r.found_word2  <= '0;
        out_data_r.found_word3  <= '0;
      end
    end
  end

  // A finished result never lands on top of one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_out.done |-> (!out_valid_r || !out_stall))
    else $error("result finished while previous result still stalled");

  // An upsert status comes with an empty name field.
  a_status_no_name: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != STATUS_NONE)) |-> (out_data_r.found_length == '0))
    else $error("upsert status with non-zero found length");

  // A taken request moves the sequencer out of idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !ctl_out.idle)
    else $error("sequencer did not leave idle after accepting a request");

  // Found length never exceeds the name width.
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.found_length <= LEN_W'(NAME_BYTES)))
    else $error("found length beyond name width");

endmodule

@@ design/bem_name_trim.sv @@
// ----------------------------------------------------------------------------
// bem_name_trim: name length and byte mask
// Count name bytes up to the first zero within the given length; zero the rest.
// ----------------------------------------------------------------------------
module bem_name_trim import bem_pkg::*; (
  input  logic [NAME_W-1:0] name_in,
  input  logic [LEN_W-1:0]  len_in,
  output logic [LEN_W-1:0]  len_out,
  output logic [NAME_W-1:0] name_out
);

  logic [NAME_BYTES-1:0] nz;
  logic [NAME_BYTES-1:0] run;

  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      nz[k] = (name_in[k*8 +: 8] != 8'd0) && (LEN_W'(k) < len_in);
    end
    run[0] = nz[0];
    for (int k = 1; k < NAME_BYTES; k++) begin
      run[k] = run[k-1] & nz[k];
    end
    // first byte that stops the name, or the full width
    len_out = LEN_W'(NAME_BYTES);
    for (int k = NAME_BYTES - 1; k >= 0; k--) begin
      if (!nz[k]) begin
        len_out = LEN_W'(k);
      end
    end
    for (int k = 0; k < NAME_BYTES; k++) begin
      name_out[k*8 +: 8] = run[k] ? name_in[k*8 +: 8] : 8'd0;
    end
  end

endmodule

@@ design/bem_name_ram.sv @@
// ----------------------------------------------------------------------------
// bem_name_ram: per-slot name store
// One write port and one registered read port at a shared slot index.
// ----------------------------------------------------------------------------
module bem_name_ram import bem_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic            wr_en,
  input  logic [IW-1:0]   idx,
  input  bem_slot_t       wr_slot,
  output bem_slot_t       rd_slot
);

  bem_slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wr_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_slot <= mem[idx];
    end
  end

endmodule

@@ design/bem_ctrl.sv @@
// ----------------------------------------------------------------------------
// bem_ctrl: table sequencer and address scan
// Walk the address store one slot a cycle through a single compare unit,
// latch the first match and first free slot, then read, update and finish.
// ----------------------------------------------------------------------------
module bem_ctrl import bem_pkg::*; #(
  parameter int TABLE_ENTRIES = 16,
  parameter int IW            = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bem_ctrl_in_t     ctl_in,
  input  logic [LEN_W-1:0] stored_len,
  output bem_ctrl_out_t    ctl_out,
  output logic [IW-1:0]    ram_idx
);

  localparam logic [IW-1:0] LAST = IW'(TABLE_ENTRIES - 1);

  bem_state_t        state_r, state_nxt;
  logic [IW-1:0]     issue_idx_r;
  logic              issuing_r;
  logic [IW-1:0]     q_idx_r;
  logic              q_live_r;
  logic [ADDR_W-1:0] addr_q_r;
  logic              valid_q_r;
  logic              hit_r;
  logic [IW-1:0]     hit_idx_r;
  logic              free_r;
  logic [IW-1:0]     free_idx_r;
  logic [1:0]        status_r, status_nxt;
  logic              valid_r [TABLE_ENTRIES];
  logic [ADDR_W-1:0] addr_mem [TABLE_ENTRIES];

  logic start_scan;
  logic scanning;
  logic match;
  logic vacant;

  assign start_scan = (state_r == S_IDLE) && ctl_in.start;
  assign scanning   = (state_r == S_SCAN);
  assign match      = q_live_r && valid_q_r && (addr_q_r == ctl_in.key);
  assign vacant     = q_live_r && !valid_q_r;
  assign ram_idx    = hit_r ? hit_idx_r : free_idx_r;

  always_comb begin
    state_nxt      = state_r;
    status_nxt     = status_r;
    ctl_out.idle   = 1'b0;
    ctl_out.done   = 1'b0;
    ctl_out.hit    = hit_r;
    ctl_out.status = status_r;
    ctl_out.ram_rd = 1'b0;
    ctl_out.ram_wr = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctl_out.idle = 1'b1;
        if (ctl_in.start) begin
          status_nxt = STATUS_NONE;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (q_live_r && (q_idx_r == LAST)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        ctl_out.ram_rd = 1'b1;
        state_nxt      = S_WRITE;
      end
      S_WRITE: begin
        state_nxt = S_DONE;
        if ((ctl_in.mode == MODE_UPSERT) && ctl_in.len_ok) begin
          if (hit_r) begin
            if ((stored_len == '0) && ctl_in.len_nz) begin
              ctl_out.ram_wr = 1'b1;
              status_nxt     = STATUS_REVEALED;
            end
          end else if (free_r) begin
            ctl_out.ram_wr = 1'b1;
            status_nxt     = STATUS_INSERTED;
          end
        end
      end
      S_DONE: begin
        if (ctl_in.out_free) begin
          ctl_out.done = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control flags and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      q_live_r  <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      q_live_r <= scanning && issuing_r;
      if (start_scan) begin
        issuing_r <= 1'b1;
        hit_r     <= 1'b0;
        free_r    <= 1'b0;
      end else if (scanning) begin
        if (issuing_r && (issue_idx_r == LAST)) begin
          issuing_r <= 1'b0;
        end
        if (match) begin
          hit_r <= 1'b1;
        end
        if (vacant) begin
          free_r <= 1'b1;
        end
      end
      if (ctl_out.ram_wr && !hit_r) begin
        valid_r[free_idx_r] <= 1'b1;
      end
    end
  end

  // scan datapath: registered read of the address store, then compare
  always_ff @(posedge clk) begin
    if (start_scan) begin
      issue_idx_r <= '0;
    end else if (scanning && issuing_r) begin
      issue_idx_r <= issue_idx_r + 1'b1;
    end
    addr_q_r  <= addr_mem[issue_idx_r];
    valid_q_r <= valid_r[issue_idx_r];
    q_idx_r   <= issue_idx_r;
    // keep only the first match and the first free slot
    if (scanning && match && !hit_r) begin
      hit_idx_r <= q_idx_r;
    end
    if (scanning && vacant && !free_r) begin
      free_idx_r <= q_idx_r;
    end
    status_r <= status_nxt;
    if (ctl_out.ram_wr && !hit_r) begin
      addr_mem[free_idx_r] <= ctl_in.key;
    end
  end

endmodule
